### rtl/core/hfna_pkg.sv
// Shared types, constants and helper functions of the hole-fill block.
// Used by every module under rtl/core; depends on nothing.
package hfna_pkg;

    // Frame limits
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    // Column index, width value, row index and height value widths
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WSZ_W = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int HSZ_W = $clog2(MAX_HEIGHT + 1);

    // Fixed field widths of the ports
    localparam int CFG_W  = 11;
    localparam int CIDX_W = 2;
    localparam int POS_W  = 10;
    localparam int CH_W   = 8;

    // Queue between front and back end, power of two
    localparam int Q_DEPTH = 2;
    localparam int QPTR_W  = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    // Reciprocal of three for the 3-neighbour average
    localparam int RECIP3       = 683;
    localparam int RECIP3_SHIFT = 11;

    typedef enum logic [CIDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_MONO   = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        REQ_PIXEL = 1'b0,
        REQ_DRAIN = 1'b1
    } t_req;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_pix;

    // One unit of work for the back end
    typedef struct packed {
        logic             emit;       // produce an output word
        logic             store;      // write the pixel into the raw line
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             down_ok;
        logic             right_ok;
        logic             up_ok;
        logic             left_ok;
        logic             frame_end;
        t_pix             pix;        // raw pixel, also the lower neighbour
    } t_op;

    // Clamp a configured width to 1..MAX_WIDTH
    function automatic logic [WSZ_W-1:0] eff_width(input logic [CFG_W-1:0] v);
        logic [WSZ_W-1:0] e;
        if (v == '0) begin
            e = WSZ_W'(1);
        end else if (32'(v) > MAX_WIDTH) begin
            e = WSZ_W'(MAX_WIDTH);
        end else begin
            e = WSZ_W'(v);
        end
        return e;
    endfunction

    // Clamp a configured height to 1..MAX_HEIGHT
    function automatic logic [HSZ_W-1:0] eff_height(input logic [CFG_W-1:0] v);
        logic [HSZ_W-1:0] e;
        if (v == '0) begin
            e = HSZ_W'(1);
        end else if (32'(v) > MAX_HEIGHT) begin
            e = HSZ_W'(MAX_HEIGHT);
        end else begin
            e = HSZ_W'(v);
        end
        return e;
    endfunction

    // Truncated average of up to four 8-bit values, given their sum
    function automatic logic [CH_W-1:0] avg_div(input logic [CH_W+1:0] sum,
                                                input logic [2:0] cnt);
        logic [2*(CH_W+2)-1:0] prod;
        logic [CH_W-1:0]       q;
        prod = (2*(CH_W+2))'(sum) * (2*(CH_W+2))'(RECIP3);
        unique case (cnt)
            3'd1:    q = sum[CH_W-1:0];
            3'd2:    q = sum[CH_W:1];
            3'd3:    q = prod[RECIP3_SHIFT +: CH_W];
            3'd4:    q = sum[CH_W+1:2];
            default: q = '0;
        endcase
        return q;
    endfunction

endpackage

### rtl/core/hfna_front.sv
// Front end: accepts pixel and drain words, tracks frame position,
// classifies each word and pushes work into the queue. Uses hfna_pkg.
module hfna_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_req_type,
    input  logic [hfna_pkg::CH_W-1:0]   i_in_blue,
    input  logic [hfna_pkg::CH_W-1:0]   i_in_green,
    input  logic [hfna_pkg::CH_W-1:0]   i_in_red,
    input  logic [hfna_pkg::WSZ_W-1:0]  i_width,
    input  logic [hfna_pkg::HSZ_W-1:0]  i_height,
    input  logic                        i_q_full,
    output logic                        o_push,
    output hfna_pkg::t_op               o_op
);

    logic [hfna_pkg::HSZ_W-1:0] r_in_row, n_in_row;
    logic [hfna_pkg::COL_W-1:0] r_in_col, n_in_col;
    logic [hfna_pkg::ROW_W-1:0] r_out_row, n_out_row;
    logic [hfna_pkg::COL_W-1:0] r_out_col, n_out_col;

    logic                       accept;
    logic [hfna_pkg::COL_W-1:0] c_in;
    logic [hfna_pkg::COL_W-1:0] c_out;
    logic [hfna_pkg::WSZ_W-1:0] c_in_next;
    logic [hfna_pkg::WSZ_W-1:0] c_out_next;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && !i_q_full;

    // Wrap stale columns back to zero against the current width
    assign c_in       = (hfna_pkg::WSZ_W'(r_in_col) >= i_width) ? '0 : r_in_col;
    assign c_out      = (hfna_pkg::WSZ_W'(r_out_col) >= i_width) ? '0 : r_out_col;
    assign c_in_next  = hfna_pkg::WSZ_W'(c_in) + hfna_pkg::WSZ_W'(1);
    assign c_out_next = hfna_pkg::WSZ_W'(c_out) + hfna_pkg::WSZ_W'(1);

    // Classify the word and advance the position counters
    always_comb begin
        n_in_row  = r_in_row;
        n_in_col  = r_in_col;
        n_out_row = r_out_row;
        n_out_col = r_out_col;
        o_push    = 1'b0;
        o_op      = '0;
        o_op.pix  = '{red: i_in_red, green: i_in_green, blue: i_in_blue};
        if (accept) begin
            if (i_req_type == hfna_pkg::REQ_PIXEL) begin
                // Drop pixels once the whole frame is in
                if (r_in_row < i_height) begin
                    o_push         = 1'b1;
                    o_op.store     = 1'b1;
                    o_op.emit      = (r_in_row != '0);
                    o_op.row       = hfna_pkg::ROW_W'(r_in_row - hfna_pkg::HSZ_W'(1));
                    o_op.col       = c_in;
                    o_op.down_ok   = 1'b1;
                    o_op.right_ok  = (c_in_next < i_width);
                    o_op.up_ok     = (r_in_row > hfna_pkg::HSZ_W'(1));
                    o_op.left_ok   = (c_in != '0);
                    o_op.frame_end = 1'b0;
                    if (c_in_next >= i_width) begin
                        n_in_col = '0;
                        n_in_row = r_in_row + hfna_pkg::HSZ_W'(1);
                    end else begin
                        n_in_col = hfna_pkg::COL_W'(c_in_next);
                    end
                    n_out_row = (n_in_row != '0)
                              ? hfna_pkg::ROW_W'(n_in_row - hfna_pkg::HSZ_W'(1)) : '0;
                    n_out_col = n_in_col;
                end
            end else begin
                // Drain only after the whole frame is in
                if (r_in_row >= i_height) begin
                    o_push         = 1'b1;
                    o_op.store     = 1'b0;
                    o_op.emit      = 1'b1;
                    o_op.row       = r_out_row;
                    o_op.col       = c_out;
                    o_op.down_ok   = 1'b0;
                    o_op.right_ok  = (c_out_next < i_width);
                    o_op.up_ok     = (r_out_row != '0);
                    o_op.left_ok   = (c_out != '0);
                    o_op.frame_end = (c_out_next >= i_width);
                    if (c_out_next >= i_width) begin
                        n_in_row  = '0;
                        n_in_col  = '0;
                        n_out_row = '0;
                        n_out_col = '0;
                    end else begin
                        n_out_col = hfna_pkg::COL_W'(c_out_next);
                    end
                end
            end
        end
    end

    // Hold position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_row  <= '0;
            r_in_col  <= '0;
            r_out_row <= '0;
            r_out_col <= '0;
        end else begin
            r_in_row  <= n_in_row;
            r_in_col  <= n_in_col;
            r_out_row <= n_out_row;
            r_out_col <= n_out_col;
        end
    end

endmodule

### rtl/core/hfna_queue.sv
// Short work queue between the front end and the back end.
// Holds hfna_pkg::t_op words; depends on hfna_pkg.
module hfna_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  hfna_pkg::t_op i_data,
    output logic          o_full,
    output logic          o_valid,
    output hfna_pkg::t_op o_data,
    input  logic          i_pop
);

    hfna_pkg::t_op               r_slot [hfna_pkg::Q_DEPTH];
    logic [hfna_pkg::QPTR_W-1:0] r_wr_ptr;
    logic [hfna_pkg::QPTR_W-1:0] r_rd_ptr;
    logic [hfna_pkg::QCNT_W-1:0] r_count, n_count;
    logic                        do_push;
    logic                        do_pop;

    assign o_full  = (r_count == hfna_pkg::QCNT_W'(hfna_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Track occupancy
    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + hfna_pkg::QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - hfna_pkg::QCNT_W'(1);
        end
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + hfna_pkg::QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + hfna_pkg::QPTR_W'(1);
            end
        end
    end

    // Store words
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

endmodule

### rtl/core/hfna_back.sv
// Back end: raw and filled line memories, neighbour average, output register.
// Takes work words from hfna_queue; depends on hfna_pkg.
module hfna_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    output logic                        o_q_pop,
    input  hfna_pkg::t_op               i_op,
    input  logic                        i_mono,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [hfna_pkg::CH_W-1:0]   o_out_blue,
    output logic [hfna_pkg::CH_W-1:0]   o_out_green,
    output logic [hfna_pkg::CH_W-1:0]   o_out_red,
    output logic [hfna_pkg::POS_W-1:0]  o_out_row,
    output logic [hfna_pkg::POS_W-1:0]  o_out_col,
    output logic                        o_was_filled,
    output logic                        o_frame_end
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_CALC = 2'b10
    } t_bstate;

    t_bstate r_state, n_state;

    // Line memories
    hfna_pkg::t_pix r_raw_mem  [hfna_pkg::MAX_WIDTH];
    hfna_pkg::t_pix r_fill_mem [hfna_pkg::MAX_WIDTH];

    hfna_pkg::t_op  r_op;
    hfna_pkg::t_pix r_own;
    hfna_pkg::t_pix r_right;
    hfna_pkg::t_pix r_up;
    hfna_pkg::t_pix r_left;

    logic           r_out_valid, n_out_valid;
    hfna_pkg::t_pix r_out_pix;
    logic [hfna_pkg::POS_W-1:0] r_out_row;
    logic [hfna_pkg::POS_W-1:0] r_out_col;
    logic           r_was_filled;
    logic           r_frame_end;

    logic [hfna_pkg::COL_W-1:0] right_addr;
    logic                       retire;
    logic                       bg;
    logic [2:0]                 cnt;
    logic [hfna_pkg::CH_W+1:0]  sum_b, sum_g, sum_r;
    hfna_pkg::t_pix             dn, rt, up, lf;
    hfna_pkg::t_pix             res;
    logic                       filled;

    assign o_q_pop    = (r_state == ST_IDLE) && i_q_valid;
    assign retire     = (r_state == ST_CALC) && (!r_out_valid || i_out_ready);
    assign right_addr = i_op.col + hfna_pkg::COL_W'(1);

    // Read lines on pop, store the raw pixel, write back the filled pixel
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_own   <= r_raw_mem[i_op.col];
            r_right <= r_raw_mem[right_addr];
            r_up    <= r_fill_mem[i_op.col];
            r_op    <= i_op;
        end
        if (o_q_pop && i_op.store) begin
            r_raw_mem[i_op.col] <= i_op.pix;
        end
        if (retire) begin
            r_fill_mem[r_op.col] <= res;
        end
    end

    // Mask out-of-image neighbours and sum per channel
    always_comb begin
        dn    = r_op.down_ok  ? r_op.pix : '0;
        rt    = r_op.right_ok ? r_right  : '0;
        up    = r_op.up_ok    ? r_up     : '0;
        lf    = r_op.left_ok  ? r_left   : '0;
        cnt   = 3'(r_op.down_ok) + 3'(r_op.right_ok) + 3'(r_op.up_ok) + 3'(r_op.left_ok);
        sum_b = 10'(dn.blue)  + 10'(rt.blue)  + 10'(up.blue)  + 10'(lf.blue);
        sum_g = 10'(dn.green) + 10'(rt.green) + 10'(up.green) + 10'(lf.green);
        sum_r = 10'(dn.red)   + 10'(rt.red)   + 10'(up.red)   + 10'(lf.red);
    end

    // Keep a foreground pixel, fill a hole with the neighbour average; mono mode clears green and red
    always_comb begin
        bg     = i_mono ? (r_own.blue == '0) : (r_own == '0);
        res    = '0;
        filled = 1'b0;
        if (!bg) begin
            res = r_own;
        end else if (cnt != '0) begin
            filled    = 1'b1;
            res.blue  = hfna_pkg::avg_div(sum_b, cnt);
            res.green = hfna_pkg::avg_div(sum_g, cnt);
            res.red   = hfna_pkg::avg_div(sum_r, cnt);
        end
        if (i_mono) begin
            res.green = '0;
            res.red   = '0;
        end
    end

    // Sequence one work word at a time
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (o_q_pop && i_op.emit) begin
                    n_state = ST_CALC;
                end
            end
            ST_CALC: begin
                if (retire) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Hold the output word until taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (retire) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_left      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (retire) begin
                r_left <= res;
            end
        end
    end

    // Load output payload
    always_ff @(posedge i_clk) begin
        if (retire) begin
            r_out_pix    <= res;
            r_out_row    <= hfna_pkg::POS_W'(r_op.row);
            r_out_col    <= hfna_pkg::POS_W'(r_op.col);
            r_was_filled <= filled;
            r_frame_end  <= r_op.frame_end;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_blue   = r_out_pix.blue;
    assign o_out_green  = r_out_pix.green;
    assign o_out_red    = r_out_pix.red;
    assign o_out_row    = r_out_row;
    assign o_out_col    = r_out_col;
    assign o_was_filled = r_was_filled;
    assign o_frame_end  = r_frame_end;

endmodule

### rtl/core/hole_fill_neighbour_average.sv
// Top level of the four-neighbour hole filler: configuration registers,
// front end, work queue and back end. Depends on hfna_pkg and the hfna_* modules.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------------------
//  cfg     | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//  in      | in        | i_in_valid / o_in_ready    | i_req_type, i_in_blue/green/red
//  out     | out       | o_out_valid / i_out_ready  | o_out_blue/green/red, o_out_row,
//          |           |                            | o_out_col, o_was_filled, o_frame_end
//
// A word that produces an output passes the back end in order: the registered
// line-memory reads, then the average and the filled-line write.
// A first-row pixel only has its reads and raw store done there; dropped words end at the front.
// The back end takes no new word until the last one has retired, so the filled-line
// and left-pixel write-back that the next word's reads depend on is already done.
// Reset is synchronous, active low; it clears counters, the left-pixel register and
// valid flags. Line memories are not cleared. A stalled output holds the back end;
// the 2-word queue then fills and o_in_ready drops.
module hole_fill_neighbour_average (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [hfna_pkg::CIDX_W-1:0]  i_cfg_index,
    input  logic [hfna_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_req_type,
    input  logic [hfna_pkg::CH_W-1:0]    i_in_blue,
    input  logic [hfna_pkg::CH_W-1:0]    i_in_green,
    input  logic [hfna_pkg::CH_W-1:0]    i_in_red,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [hfna_pkg::CH_W-1:0]    o_out_blue,
    output logic [hfna_pkg::CH_W-1:0]    o_out_green,
    output logic [hfna_pkg::CH_W-1:0]    o_out_red,
    output logic [hfna_pkg::POS_W-1:0]   o_out_row,
    output logic [hfna_pkg::POS_W-1:0]   o_out_col,
    output logic                         o_was_filled,
    output logic                         o_frame_end
);

    logic [hfna_pkg::WSZ_W-1:0] r_width;
    logic [hfna_pkg::HSZ_W-1:0] r_height;
    logic                       r_mono;

    logic          q_push;
    logic          q_full;
    logic          q_valid;
    logic          q_pop;
    hfna_pkg::t_op front_op;
    hfna_pkg::t_op q_op;

    assign o_cfg_ready = 1'b1;

    // Store configuration, clamped to the supported frame size
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= hfna_pkg::WSZ_W'(256);
            r_height <= hfna_pkg::HSZ_W'(256);
            r_mono   <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                hfna_pkg::CFG_WIDTH:  r_width  <= hfna_pkg::eff_width(i_cfg_data);
                hfna_pkg::CFG_HEIGHT: r_height <= hfna_pkg::eff_height(i_cfg_data);
                hfna_pkg::CFG_MONO:   r_mono   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    hfna_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_req_type (i_req_type),
        .i_in_blue  (i_in_blue),
        .i_in_green (i_in_green),
        .i_in_red   (i_in_red),
        .i_width    (r_width),
        .i_height   (r_height),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_op       (front_op)
    );

    hfna_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (front_op),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_op),
        .i_pop   (q_pop)
    );

    hfna_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .o_q_pop      (q_pop),
        .i_op         (q_op),
        .i_mono       (r_mono),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_blue   (o_out_blue),
        .o_out_green  (o_out_green),
        .o_out_red    (o_out_red),
        .o_out_row    (o_out_row),
        .o_out_col    (o_out_col),
        .o_was_filled (o_was_filled),
        .o_frame_end  (o_frame_end)
    );

endmodule

### rtl/core/hfna_checker.sv
// Port-level checks for hole_fill_neighbour_average, bound to the top level.
// Depends on hfna_pkg for port widths.
module hfna_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_cfg_valid,
    input logic                         o_cfg_ready,
    input logic [hfna_pkg::CIDX_W-1:0]  i_cfg_index,
    input logic [hfna_pkg::CFG_W-1:0]   i_cfg_data,
    input logic                         i_in_valid,
    input logic                         o_in_ready,
    input logic                         i_req_type,
    input logic [hfna_pkg::CH_W-1:0]    i_in_blue,
    input logic [hfna_pkg::CH_W-1:0]    i_in_green,
    input logic [hfna_pkg::CH_W-1:0]    i_in_red,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic [hfna_pkg::CH_W-1:0]    o_out_blue,
    input logic [hfna_pkg::CH_W-1:0]    o_out_green,
    input logic [hfna_pkg::CH_W-1:0]    o_out_red,
    input logic [hfna_pkg::POS_W-1:0]   o_out_row,
    input logic [hfna_pkg::POS_W-1:0]   o_out_col,
    input logic                         o_was_filled,
    input logic                         o_frame_end
);

    // Hold a stalled output word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_out_blue) && $stable(o_out_green) && $stable(o_out_red) &&
            $stable(o_out_row) && $stable(o_out_col) && $stable(o_was_filled) &&
            $stable(o_frame_end))
        else $error("output payload changed while stalled");

    // Reset empties the output register
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // A new frame restarts at the top-left pixel
    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_frame_end |=>
            !o_out_valid || (o_out_row == '0 && o_out_col == '0))
        else $error("frame did not restart at row 0, column 0");

    // Never present an unknown output word
    a_out_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !$isunknown({o_out_blue, o_out_green, o_out_red, o_out_row,
                                     o_out_col, o_was_filled, o_frame_end}))
        else $error("unknown output word");

endmodule

bind hole_fill_neighbour_average hfna_checker u_hfna_checker (.*);

### sim/tb_hole_fill_neighbour_average.sv
// Self-checking testbench for hole_fill_neighbour_average: a directed table, a tallest frame, then
// random frames, with every output word checked against a behavioral fill predictor or a fixed table word.
// Depends on hfna_pkg and the hole_fill_neighbour_average RTL.
module tb_hole_fill_neighbour_average;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_PAUSE = 13;
    localparam int unsigned SETTLE    = 8;        // quiet cycles before a register write
    localparam int unsigned TAIL      = 20;       // cycles to watch after the last word
    localparam int unsigned LIMIT     = 1000000;  // run watchdog, in clock cycles
    localparam int unsigned ITEM_GOAL = 600;      // frame words in the random part

    // Index with no register behind it
    localparam logic [hfna_pkg::CIDX_W-1:0] CFG_SPARE = hfna_pkg::CIDX_W'(3);

    // One filled output pixel as it leaves the block
    typedef struct packed {
        logic [hfna_pkg::CH_W-1:0]  blue;
        logic [hfna_pkg::CH_W-1:0]  green;
        logic [hfna_pkg::CH_W-1:0]  red;
        logic [hfna_pkg::POS_W-1:0] row;
        logic [hfna_pkg::POS_W-1:0] col;
        logic                       filled;
        logic                       last;
    } t_fill_word;

    // One line of the directed table: a register write or an input word
    typedef struct {
        bit                          is_cfg;
        logic [hfna_pkg::CIDX_W-1:0] idx;
        logic [hfna_pkg::CFG_W-1:0]  data;
        hfna_pkg::t_req              req;
        hfna_pkg::t_pix              px;
        bit                          typed;
        t_fill_word                  want;
    } t_plan_row;

    logic                         i_clk       = 1'b0;
    logic                         i_rst_n     = 1'b0;
    logic                         i_cfg_valid = 1'b0;
    logic                         o_cfg_ready;
    logic [hfna_pkg::CIDX_W-1:0]  i_cfg_index = '0;
    logic [hfna_pkg::CFG_W-1:0]   i_cfg_data  = '0;
    logic                         i_in_valid  = 1'b0;
    logic                         o_in_ready;
    logic                         i_req_type  = 1'b0;
    logic [hfna_pkg::CH_W-1:0]    i_in_blue   = '0;
    logic [hfna_pkg::CH_W-1:0]    i_in_green  = '0;
    logic [hfna_pkg::CH_W-1:0]    i_in_red    = '0;
    logic                         o_out_valid;
    logic                         i_out_ready = 1'b0;
    logic [hfna_pkg::CH_W-1:0]    o_out_blue;
    logic [hfna_pkg::CH_W-1:0]    o_out_green;
    logic [hfna_pkg::CH_W-1:0]    o_out_red;
    logic [hfna_pkg::POS_W-1:0]   o_out_row;
    logic [hfna_pkg::POS_W-1:0]   o_out_col;
    logic                         o_was_filled;
    logic                         o_frame_end;

    // Predictor state: configuration, line stores and frame counters
    logic [hfna_pkg::CFG_W-1:0] cfg_w    = hfna_pkg::CFG_W'(256);
    logic [hfna_pkg::CFG_W-1:0] cfg_h    = hfna_pkg::CFG_W'(256);
    logic                       cfg_mono = 1'b0;
    hfna_pkg::t_pix             raw_row  [hfna_pkg::MAX_WIDTH];
    hfna_pkg::t_pix             done_row [hfna_pkg::MAX_WIDTH];
    hfna_pkg::t_pix             left_px  = '0;
    int unsigned                next_in_row  = 0;
    int unsigned                next_in_col  = 0;
    int unsigned                next_out_row = 0;
    int unsigned                next_out_col = 0;

    t_fill_word  due_pixels [$];
    int unsigned faults    = 0;
    int unsigned fed_words = 0;
    int unsigned cycle_no  = 0;
    bit          burst     = 1'b0;

    hole_fill_neighbour_average DUT (.*);

    always #1 i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_no <= cycle_no + 1;
        if (cycle_no >= LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding", cycle_no,
                     due_pixels.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic int unsigned clamp_size(logic [hfna_pkg::CFG_W-1:0] v,
                                               int unsigned top);
        int unsigned s;
        s = v;
        if (s == 0) s = 1;
        if (s > top) s = top;
        return s;
    endfunction

    function automatic int unsigned pause_len();
        return burst ? 0 : $urandom_range(0, MAX_PAUSE);
    endfunction

    function automatic logic [hfna_pkg::CH_W-1:0] draw_chan();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return hfna_pkg::CH_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Random pixel; a share are holes, and in color mode some only look like one
    function automatic hfna_pkg::t_pix draw_pixel(int unsigned hole_pct);
        hfna_pkg::t_pix p;
        p.blue  = draw_chan();
        p.green = draw_chan();
        p.red   = draw_chan();
        if ($urandom_range(0, 99) < hole_pct) begin
            p.blue = '0;
            if (cfg_mono ? ($urandom_range(0, 1) == 0) : ($urandom_range(0, 5) != 0)) begin
                p.green = '0;
                p.red   = '0;
            end
        end
        return p;
    endfunction

    function automatic logic [hfna_pkg::CFG_W-1:0] draw_size(int unsigned top);
        if ($urandom_range(0, 9) == 0) return hfna_pkg::CFG_W'($urandom_range(0, 1));
        return hfna_pkg::CFG_W'($urandom_range(1, top));
    endfunction

    function automatic t_plan_row cfg_row(logic [hfna_pkg::CIDX_W-1:0] idx,
                                          logic [hfna_pkg::CFG_W-1:0] data);
        t_plan_row r;
        r        = '{req: hfna_pkg::REQ_PIXEL, default: '0};
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.data   = data;
        return r;
    endfunction

    function automatic t_plan_row px_row(hfna_pkg::t_req req, int b, int g, int r_ch);
        t_plan_row r;
        r          = '{req: hfna_pkg::REQ_PIXEL, default: '0};
        r.req      = req;
        r.px.blue  = hfna_pkg::CH_W'(b);
        r.px.green = hfna_pkg::CH_W'(g);
        r.px.red   = hfna_pkg::CH_W'(r_ch);
        return r;
    endfunction

    function automatic t_plan_row known_row(hfna_pkg::t_req req, int b, int g, int r_ch,
                                            t_fill_word want);
        t_plan_row r;
        r       = px_row(req, b, g, r_ch);
        r.typed = 1'b1;
        r.want  = want;
        return r;
    endfunction

    // Fill one pixel of the held row and update the filled line and left pixel
    task automatic fill_one(input int unsigned row, input int unsigned col,
                            input bit has_down, input hfna_pkg::t_pix down,
                            input int unsigned w, input int unsigned h,
                            output t_fill_word wd);
        hfna_pkg::t_pix own;
        hfna_pkg::t_pix res;
        hfna_pkg::t_pix nbr [4];
        int unsigned    cnt;
        int unsigned    sb;
        int unsigned    sg;
        int unsigned    sr;
        bit             hole;
        own  = raw_row[col];
        res  = '0;
        cnt  = 0;
        sb   = 0;
        sg   = 0;
        sr   = 0;
        hole = (own.blue == '0) && (cfg_mono || (own.green == '0 && own.red == '0));
        if (!hole) begin
            res = own;
            if (cfg_mono) begin
                res.green = '0;
                res.red   = '0;
            end
        end else begin
            // lower and right are raw, upper and left already filled
            if (has_down && row + 1 < h) begin
                nbr[cnt] = down;
                cnt++;
            end
            if (col + 1 < w) begin
                nbr[cnt] = raw_row[col + 1];
                cnt++;
            end
            if (row > 0) begin
                nbr[cnt] = done_row[col];
                cnt++;
            end
            if (col > 0) begin
                nbr[cnt] = left_px;
                cnt++;
            end
            for (int unsigned n = 0; n < cnt; n++) begin
                sb += nbr[n].blue;
                sg += nbr[n].green;
                sr += nbr[n].red;
            end
            if (cnt > 0) begin
                res.blue = hfna_pkg::CH_W'(sb / cnt);
                if (!cfg_mono) begin
                    res.green = hfna_pkg::CH_W'(sg / cnt);
                    res.red   = hfna_pkg::CH_W'(sr / cnt);
                end
            end
        end
        done_row[col] = res;
        left_px       = res;
        wd        = '0;
        wd.blue   = res.blue;
        wd.green  = res.green;
        wd.red    = res.red;
        wd.row    = hfna_pkg::POS_W'(row);
        wd.col    = hfna_pkg::POS_W'(col);
        wd.filled = (cnt > 0);
    endtask

    // Advance the predictor by one accepted input word
    task automatic predict_fill(input hfna_pkg::t_req req, input hfna_pkg::t_pix px,
                                output bit made, output t_fill_word wd);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        w    = clamp_size(cfg_w, hfna_pkg::MAX_WIDTH);
        h    = clamp_size(cfg_h, hfna_pkg::MAX_HEIGHT);
        made = 1'b0;
        wd   = '0;
        if (req == hfna_pkg::REQ_PIXEL) begin
            // pixels past the last row are dropped until the drain ends
            if (next_in_row < h) begin
                if (next_in_col >= w) next_in_col = 0;
                c = next_in_col;
                if (next_in_row >= 1) begin
                    fill_one(next_in_row - 1, c, 1'b1, px, w, h, wd);
                    made = 1'b1;
                end
                raw_row[c] = px;
                if (c + 1 >= w) begin
                    next_in_col = 0;
                    next_in_row++;
                end else begin
                    next_in_col = c + 1;
                end
                next_out_row = (next_in_row >= 1) ? next_in_row - 1 : 0;
                next_out_col = next_in_col;
            end
        end else if (next_in_row >= h) begin
            // drain the last row; early and late drains are dropped
            if (next_out_col >= w) next_out_col = 0;
            fill_one(next_out_row, next_out_col, 1'b0, '0, w, h, wd);
            made = 1'b1;
            if (next_out_col + 1 >= w) begin
                wd.last      = 1'b1;
                next_in_row  = 0;
                next_in_col  = 0;
                next_out_row = 0;
                next_out_col = 0;
            end else begin
                next_out_col++;
            end
        end
    endtask

    // Send one input word, then record what it should produce
    task automatic feed(input hfna_pkg::t_req req, input hfna_pkg::t_pix px,
                        input bit typed = 1'b0, input t_fill_word want = '0);
        int unsigned gap;
        bit          made;
        t_fill_word  guess;
        gap = pause_len();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_in_blue  <= px.blue;
        i_in_green <= px.green;
        i_in_red   <= px.red;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        predict_fill(req, px, made, guess);
        if (made) due_pixels.push_back(typed ? want : guess);
    endtask

    // Drop valid and hold until every expected word is out
    task automatic wait_quiet();
        @(negedge i_clk) i_in_valid <= 1'b0;
        while (due_pixels.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [hfna_pkg::CIDX_W-1:0] idx,
                             input logic [hfna_pkg::CFG_W-1:0] data);
        wait_quiet();
        repeat (SETTLE) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            hfna_pkg::CFG_WIDTH:  cfg_w    = data;
            hfna_pkg::CFG_HEIGHT: cfg_h    = data;
            hfna_pkg::CFG_MONO:   cfg_mono = data[0];
            default:              ;
        endcase
        @(negedge i_clk) i_cfg_valid <= 1'b0;
    endtask

    // One whole frame, with dropped words mixed in
    task automatic run_frame(input int unsigned hole_pct);
        int unsigned w;
        int unsigned h;
        w = clamp_size(cfg_w, hfna_pkg::MAX_WIDTH);
        h = clamp_size(cfg_h, hfna_pkg::MAX_HEIGHT);
        for (int unsigned n = 0; n < w * h; n++) begin
            if ($urandom_range(0, 24) == 0) feed(hfna_pkg::REQ_DRAIN, draw_pixel(hole_pct));
            if ($urandom_range(0, 199) == 0) wait_quiet();
            feed(hfna_pkg::REQ_PIXEL, draw_pixel(hole_pct));
        end
        // stray pixel once the frame is full
        if ($urandom_range(0, 3) == 0) feed(hfna_pkg::REQ_PIXEL, draw_pixel(hole_pct));
        for (int unsigned n = 0; n < w; n++) feed(hfna_pkg::REQ_DRAIN, draw_pixel(hole_pct));
        // drain after the frame is done
        if ($urandom_range(0, 3) == 0) feed(hfna_pkg::REQ_DRAIN, draw_pixel(hole_pct));
        fed_words += w * h + w;
    endtask

    // Output side: stall at random, check each word against the oldest expectation
    initial begin
        t_fill_word  got;
        t_fill_word  want;
        int unsigned stall;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = pause_len();
            @(negedge i_clk);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            got = {o_out_blue, o_out_green, o_out_red, o_out_row, o_out_col,
                   o_was_filled, o_frame_end};
            if (due_pixels.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("cycle %0d: unexpected word b%0d g%0d r%0d (%0d,%0d)",
                             cycle_no, got.blue, got.green, got.red, got.row, got.col);
            end else begin
                want = due_pixels.pop_front();
                if (got.blue !== want.blue || got.green !== want.green ||
                    got.red !== want.red || got.row !== want.row ||
                    got.col !== want.col || got.filled !== want.filled ||
                    got.last !== want.last) begin
                    faults++;
                    if (faults <= 10) begin
                        $display("cycle %0d: want b%0d g%0d r%0d (%0d,%0d) fill%0b end%0b",
                                 cycle_no, want.blue, want.green, want.red, want.row,
                                 want.col, want.filled, want.last);
                        $display("          got  b%0d g%0d r%0d (%0d,%0d) fill%0b end%0b",
                                 got.blue, got.green, got.red, got.row, got.col,
                                 got.filled, got.last);
                    end
                end
            end
        end
    end

    // Input side: reset, directed table, tallest frame, random frames, wrap-up
    initial begin
        t_plan_row                   plan [$];
        int unsigned                 goal;
        logic [hfna_pkg::CIDX_W-1:0] idx;
        logic [hfna_pkg::CFG_W-1:0]  mono_data;
        int unsigned                 frames;
        int unsigned                 hole_pct;

        plan = '{
            // 1x1 frame from zero sizes; early drain, full-frame pixel, late drain
            cfg_row(hfna_pkg::CFG_WIDTH, '0),
            cfg_row(hfna_pkg::CFG_HEIGHT, '0),
            cfg_row(hfna_pkg::CFG_MONO, '0),
            cfg_row(CFG_SPARE, '1),
            px_row(hfna_pkg::REQ_DRAIN, 0, 0, 0),
            px_row(hfna_pkg::REQ_PIXEL, 0, 0, 0),
            px_row(hfna_pkg::REQ_PIXEL, 255, 255, 255),
            known_row(hfna_pkg::REQ_DRAIN, 170, 85, 1,
                      {8'd0, 8'd0, 8'd0, 10'd0, 10'd0, 1'b0, 1'b1}),
            px_row(hfna_pkg::REQ_DRAIN, 0, 0, 0),
            px_row(hfna_pkg::REQ_PIXEL, 255, 255, 255),
            known_row(hfna_pkg::REQ_DRAIN, 0, 0, 0,
                      {8'd255, 8'd255, 8'd255, 10'd0, 10'd0, 1'b0, 1'b1}),
            // 3x2 color frame with holes at a corner and mid-row
            cfg_row(hfna_pkg::CFG_WIDTH, hfna_pkg::CFG_W'(3)),
            cfg_row(hfna_pkg::CFG_HEIGHT, hfna_pkg::CFG_W'(2)),
            px_row(hfna_pkg::REQ_PIXEL, 0, 0, 0),
            px_row(hfna_pkg::REQ_PIXEL, 10, 20, 30),
            px_row(hfna_pkg::REQ_PIXEL, 255, 0, 1),
            px_row(hfna_pkg::REQ_DRAIN, 9, 9, 9),
            px_row(hfna_pkg::REQ_PIXEL, 7, 8, 9),
            px_row(hfna_pkg::REQ_PIXEL, 0, 0, 0),
            px_row(hfna_pkg::REQ_PIXEL, 255, 255, 255),
            px_row(hfna_pkg::REQ_DRAIN, 0, 0, 0),
            px_row(hfna_pkg::REQ_DRAIN, 0, 0, 0),
            px_row(hfna_pkg::REQ_DRAIN, 0, 0, 0),
            // 2x2 mono frame; green and red carry junk on holes
            cfg_row(hfna_pkg::CFG_MONO, hfna_pkg::CFG_W'(11'h401)),
            cfg_row(hfna_pkg::CFG_WIDTH, hfna_pkg::CFG_W'(2)),
            px_row(hfna_pkg::REQ_PIXEL, 0, 50, 60),
            px_row(hfna_pkg::REQ_PIXEL, 200, 1, 2),
            px_row(hfna_pkg::REQ_PIXEL, 0, 255, 255),
            px_row(hfna_pkg::REQ_PIXEL, 3, 0, 0),
            px_row(hfna_pkg::REQ_DRAIN, 0, 0, 0),
            px_row(hfna_pkg::REQ_DRAIN, 255, 255, 255)
        };

        repeat (7) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        foreach (plan[k]) begin
            if (plan[k].is_cfg) write_reg(plan[k].idx, plan[k].data);
            else feed(plan[k].req, plan[k].px, plan[k].typed, plan[k].want);
        end

        // tallest frame, one column, mono
        write_reg(hfna_pkg::CFG_MONO, hfna_pkg::CFG_W'(1));
        write_reg(hfna_pkg::CFG_WIDTH, hfna_pkg::CFG_W'(1));
        write_reg(hfna_pkg::CFG_HEIGHT,
                  $urandom_range(0, 1) ? hfna_pkg::CFG_W'(hfna_pkg::MAX_HEIGHT) : '1);
        run_frame(40);

        // small random frames; registers rewritten between them, starting at a random index
        goal = fed_words + ITEM_GOAL;
        while (fed_words < goal) begin
            burst     = 1'b0;
            idx       = hfna_pkg::CIDX_W'($urandom_range(0, 3));
            mono_data = hfna_pkg::CFG_W'($urandom_range(0, 1));
            if ($urandom_range(0, 3) == 0)
                mono_data[hfna_pkg::CFG_W-1:1] = (hfna_pkg::CFG_W-1)'($urandom);
            for (int s = 0; s < 4; s++) begin
                case (idx)
                    hfna_pkg::CFG_WIDTH:
                        if ($urandom_range(0, 3) != 0)
                            write_reg(hfna_pkg::CFG_WIDTH, draw_size(12));
                    hfna_pkg::CFG_HEIGHT:
                        if ($urandom_range(0, 3) != 0)
                            write_reg(hfna_pkg::CFG_HEIGHT, draw_size(6));
                    hfna_pkg::CFG_MONO:
                        if ($urandom_range(0, 2) != 0)
                            write_reg(hfna_pkg::CFG_MONO, mono_data);
                    default:
                        if ($urandom_range(0, 15) == 0)
                            write_reg(CFG_SPARE, hfna_pkg::CFG_W'($urandom));
                endcase
                idx = idx + 1'b1;
            end
            burst    = ($urandom_range(0, 3) == 0);
            frames   = $urandom_range(1, 3);
            hole_pct = ($urandom_range(0, 3) == 0) ? 85 : $urandom_range(10, 50);
            repeat (frames) run_frame(hole_pct);
        end

        burst = 1'b0;
        wait_quiet();
        repeat (TAIL) @(posedge i_clk);
        if (faults == 0 && due_pixels.size() == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

endmodule
